// ----- src/orbc_pkg.sv -----
// orbc_pkg: types and constants shared by the one-rotor byte cipher.
// No dependencies; every other file but orbc_ram takes names from here by scope.
package orbc_pkg;

  localparam int ROTOR_SIZE = 256;
  localparam int IDX_W      = 8;
  localparam int KEY_LENGTH = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_TAIL_W = 40;

  localparam logic [31:0] SEED_START  = 32'd123;
  localparam logic [15:0] GEN_MODULUS = 16'd65521;
  localparam logic [7:0]  IDX_MASK    = 8'hff;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HEAD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TAIL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECURE_MODE = 2'd2;

  localparam logic CMD_CIPHER = 1'b0;
  localparam logic CMD_REKEY  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_CB, ST_CC, ST_CR, ST_CI, ST_CO, ST_CW,
    ST_KS, ST_INIT, ST_LSEED, ST_LMODS, ST_LMODW, ST_LDIVW,
    ST_SW0, ST_SW1, ST_SW2, ST_SW3, ST_RK, ST_DIV2W, ST_PRD, ST_PCK,
    ST_PW0, ST_PW1, ST_LNEXT, ST_INV
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] seed;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic       start;
    logic [7:0] num;
    logic [8:0] den;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] rem;
  } div_rsp_t;

endpackage

// ----- src/orbc_if.sv -----
// orbc_if: handshake interfaces for the input, result and configuration words.
// Depends on orbc_pkg for widths.
interface orbc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] plain_byte;
  modport source (output valid, cmd, plain_byte, input ready);
  modport sink (input valid, cmd, plain_byte, output ready);
endinterface

interface orbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  modport source (output valid, cipher_byte, input ready);
  modport sink (input valid, cipher_byte, output ready);
endinterface

interface orbc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [orbc_pkg::CFG_IDX_W-1:0]   idx;
  logic [orbc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

// ----- src/orbc_ram.sv -----
// orbc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module orbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/orbc_mod.sv -----
// orbc_mod: iterative signed remainder of a 32-bit seed by 65521.
// Folds 2^16 = 15 (mod 65521) once a cycle; depends on orbc_pkg.
module orbc_mod (
  input  logic               clk,
  input  logic               rst,
  input  orbc_pkg::mod_req_t req,
  output orbc_pkg::mod_rsp_t rsp
);

  logic        busy;
  logic        neg;
  logic [31:0] acc;
  logic [15:0] low;
  logic [15:0] red;

  always_comb begin
    low = acc[15:0];
    red = (low >= orbc_pkg::GEN_MODULUS) ? low - orbc_pkg::GEN_MODULUS : low;
    rsp.done = busy && (acc[31:16] == 16'd0);
    rsp.rem  = neg ? 16'(16'd0 - red) : red;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (rsp.done) begin
      busy <= 1'b0;
    end
    if (req.start) begin
      neg <= req.seed[31];
      acc <= req.seed[31] ? 32'd0 - req.seed : req.seed;
    end else if (busy && acc[31:16] != 16'd0) begin
      // fold the high half: hi * 15 + lo
      acc <= ({16'd0, acc[31:16]} << 4) - {16'd0, acc[31:16]} + {16'd0, acc[15:0]};
    end
  end

endmodule

// ----- src/orbc_rem.sv -----
// orbc_rem: restoring remainder of an 8-bit value by a divisor of 1 to 256.
// One quotient bit a cycle; depends on orbc_pkg.
module orbc_rem (
  input  logic               clk,
  input  logic               rst,
  input  orbc_pkg::div_req_t req,
  output orbc_pkg::div_rsp_t rsp
);

  logic       busy;
  logic       done;
  logic [2:0] step;
  logic [7:0] num;
  logic [8:0] den;
  logic [8:0] rem;
  logic [8:0] trial;

  assign trial    = {rem[7:0], num[7]};
  assign rsp.done = done;
  assign rsp.rem  = rem[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= 9'd0;
    end else if (busy) begin
      num <= {num[6:0], 1'b0};
      rem <= (trial >= den) ? trial - den : trial;
    end
  end

endmodule

// ----- src/one_rotor_byte_cipher_top.sv -----
// one_rotor_byte_cipher_top: sequencer, tables and counters of the cipher.
// Depends on orbc_pkg, orbc_if, orbc_ram, orbc_mod and orbc_rem.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    cmd, plain_byte
//  out_ch   out  valid/ready    cipher_byte
//  cfg_ch   in   valid/ready    idx (0 key_head, 1 key_tail, 2 secure_mode), data
//
// A cipher word passes ST_CR, ST_CI and ST_CO, after ST_CB and ST_CC in
// secure mode: one state per dependent table read, each RAM having one
// registered read port. Every 256th word in secure mode adds a deck reshuffle
// of 256 rounds that use the mod-65521 folder and the remainder unit. A rekey
// runs the key schedule over the 13 key bytes, fills the tables over 256
// entries, runs 256 shuffle rounds and builds the inverse table; a round that
// pairs reflector slots passes ST_PRD and ST_PCK again for each extra probe.
// After reset a clearing pass over all 256 addresses zeroes the four tables;
// no word is taken meanwhile. Configuration words are always taken. A word
// is taken while a result waits in the output register, but not in ST_CW.
module one_rotor_byte_cipher_top (
  input  logic       clk,
  input  logic       rst,
  orbc_in_if.sink    in_ch,
  orbc_out_if.source out_ch,
  orbc_cfg_if.sink   cfg_ch
);

  orbc_pkg::state_t state, state_next;

  // configuration registers
  logic [63:0]                   key_head;
  logic [orbc_pkg::KEY_TAIL_W-1:0] key_tail;
  logic                          secure_mode;

  // sequencer and datapath registers
  logic [8:0]  cnt;
  logic [3:0]  kmod;
  logic        deck_mode;
  logic [31:0] sched_seed;
  logic [31:0] shuf_seed;
  logic [7:0]  c;
  logic [7:0]  o1;
  logic [7:0]  so;
  logic [7:0]  bp;
  logic [7:0]  rev;
  logic [7:0]  ic;
  logic [7:0]  tk;
  logic [7:0]  r_hi;
  logic [7:0]  tries;
  logic [7:0]  res;
  logic        out_valid;
  logic [7:0]  out_data;

  // RAM ports
  logic       fwd_we, inv_we, refl_we, deck_we;
  logic [7:0] fwd_wa, inv_wa, refl_wa, deck_wa;
  logic [7:0] fwd_wd, inv_wd, refl_wd, deck_wd;
  logic [7:0] fwd_ra, inv_ra, refl_ra, deck_ra;
  logic [7:0] fwd_rd, inv_rd, refl_rd, deck_rd;

  orbc_pkg::mod_req_t mod_req;
  orbc_pkg::mod_rsp_t mod_rsp;
  orbc_pkg::div_req_t div_req;
  orbc_pkg::div_rsp_t div_rsp;

  logic        in_acc;
  logic        out_free;
  logic [7:0]  k;
  logic [7:0]  m_rd;
  logic [31:0] seed_sel;
  logic [31:0] kw;
  logic [7:0]  ciph;
  logic [8:0]  ic_inc;

  // key byte j, sign-extended
  function automatic logic [31:0] key_word(input logic [63:0] head,
                                           input logic [39:0] tail,
                                           input logic [3:0] j);
    logic [7:0] b;
    case (j)
      4'd0:  b = head[7:0];
      4'd1:  b = head[15:8];
      4'd2:  b = head[23:16];
      4'd3:  b = head[31:24];
      4'd4:  b = head[39:32];
      4'd5:  b = head[47:40];
      4'd6:  b = head[55:48];
      4'd7:  b = head[63:56];
      4'd8:  b = tail[7:0];
      4'd9:  b = tail[15:8];
      4'd10: b = tail[23:16];
      4'd11: b = tail[31:24];
      4'd12: b = tail[39:32];
      default: b = 8'd0;
    endcase
    return {{24{b[7]}}, b};
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign k        = ~cnt[7:0];  // k = 255 - i
  assign m_rd     = deck_mode ? deck_rd : fwd_rd;
  assign seed_sel = deck_mode ? shuf_seed : sched_seed;
  assign kw       = key_word(key_head, key_tail, kmod);
  assign ciph     = inv_rd - o1;
  assign ic_inc   = {1'b0, ic} + 9'd1;

  assign out_ch.valid       = out_valid;
  assign out_ch.cipher_byte = out_data;
  assign cfg_ch.ready       = 1'b1;

  orbc_ram #(.WIDTH(8), .DEPTH(orbc_pkg::ROTOR_SIZE)) u_fwd (
    .clk(clk), .we(fwd_we), .waddr(fwd_wa), .wdata(fwd_wd), .raddr(fwd_ra), .rdata(fwd_rd)
  );
  orbc_ram #(.WIDTH(8), .DEPTH(orbc_pkg::ROTOR_SIZE)) u_inv (
    .clk(clk), .we(inv_we), .waddr(inv_wa), .wdata(inv_wd), .raddr(inv_ra), .rdata(inv_rd)
  );
  orbc_ram #(.WIDTH(8), .DEPTH(orbc_pkg::ROTOR_SIZE)) u_refl (
    .clk(clk), .we(refl_we), .waddr(refl_wa), .wdata(refl_wd), .raddr(refl_ra),
    .rdata(refl_rd)
  );
  orbc_ram #(.WIDTH(8), .DEPTH(orbc_pkg::ROTOR_SIZE)) u_deck (
    .clk(clk), .we(deck_we), .waddr(deck_wa), .wdata(deck_wd), .raddr(deck_ra),
    .rdata(deck_rd)
  );

  orbc_mod u_mod (.clk(clk), .rst(rst), .req(mod_req), .rsp(mod_rsp));
  orbc_rem u_rem (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      orbc_pkg::ST_CLR:   if (cnt[7:0] == orbc_pkg::IDX_MASK) state_next = orbc_pkg::ST_IDLE;
      orbc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.cmd == orbc_pkg::CMD_REKEY) state_next = orbc_pkg::ST_KS;
          else if (secure_mode) state_next = orbc_pkg::ST_CB;
          else state_next = orbc_pkg::ST_CR;
        end
      end
      orbc_pkg::ST_CB:    state_next = orbc_pkg::ST_CC;
      orbc_pkg::ST_CC:    state_next = orbc_pkg::ST_CR;
      orbc_pkg::ST_CR:    state_next = orbc_pkg::ST_CI;
      orbc_pkg::ST_CI:    state_next = orbc_pkg::ST_CO;
      orbc_pkg::ST_CO, orbc_pkg::ST_CW: begin
        if (!out_free) state_next = orbc_pkg::ST_CW;
        else if (bp == orbc_pkg::IDX_MASK && secure_mode) state_next = orbc_pkg::ST_LSEED;
        else state_next = orbc_pkg::ST_IDLE;
      end
      orbc_pkg::ST_KS:    if (cnt[3:0] == 4'(orbc_pkg::KEY_LENGTH - 1))
                            state_next = orbc_pkg::ST_INIT;
      orbc_pkg::ST_INIT:  if (cnt[7:0] == orbc_pkg::IDX_MASK) state_next = orbc_pkg::ST_LSEED;
      orbc_pkg::ST_LSEED: state_next = orbc_pkg::ST_LMODS;
      orbc_pkg::ST_LMODS: state_next = orbc_pkg::ST_LMODW;
      orbc_pkg::ST_LMODW: if (mod_rsp.done) state_next = orbc_pkg::ST_LDIVW;
      orbc_pkg::ST_LDIVW: if (div_rsp.done) state_next = orbc_pkg::ST_SW0;
      orbc_pkg::ST_SW0:   state_next = orbc_pkg::ST_SW1;
      orbc_pkg::ST_SW1:   state_next = orbc_pkg::ST_SW2;
      orbc_pkg::ST_SW2:   state_next = orbc_pkg::ST_SW3;
      orbc_pkg::ST_SW3:   state_next = (deck_mode || k == 8'd0) ? orbc_pkg::ST_LNEXT
                                                                : orbc_pkg::ST_RK;
      orbc_pkg::ST_RK:    state_next = (refl_rd != 8'd0) ? orbc_pkg::ST_LNEXT
                                                         : orbc_pkg::ST_DIV2W;
      orbc_pkg::ST_DIV2W: if (div_rsp.done) state_next = orbc_pkg::ST_PRD;
      orbc_pkg::ST_PRD:   state_next = orbc_pkg::ST_PCK;
      orbc_pkg::ST_PCK: begin
        if (refl_rd != 8'd0 && tries < k) state_next = orbc_pkg::ST_PRD;
        else if (refl_rd != 8'd0) state_next = orbc_pkg::ST_LNEXT;
        else state_next = orbc_pkg::ST_PW0;
      end
      orbc_pkg::ST_PW0:   state_next = orbc_pkg::ST_PW1;
      orbc_pkg::ST_PW1:   state_next = orbc_pkg::ST_LNEXT;
      orbc_pkg::ST_LNEXT: begin
        if (cnt[7:0] != orbc_pkg::IDX_MASK) state_next = orbc_pkg::ST_LSEED;
        else if (deck_mode) state_next = orbc_pkg::ST_IDLE;
        else state_next = orbc_pkg::ST_INV;
      end
      orbc_pkg::ST_INV:   if (cnt[8]) state_next = orbc_pkg::ST_IDLE;
      default:            state_next = orbc_pkg::ST_IDLE;
    endcase
  end

  // RAM, unit and handshake controls
  always_comb begin
    in_ch.ready = 1'b0;
    fwd_we = 1'b0; inv_we = 1'b0; refl_we = 1'b0; deck_we = 1'b0;
    fwd_wa = cnt[7:0]; inv_wa = cnt[7:0]; refl_wa = cnt[7:0]; deck_wa = cnt[7:0];
    fwd_wd = 8'd0; inv_wd = 8'd0; refl_wd = 8'd0; deck_wd = 8'd0;
    fwd_ra = 8'd0; inv_ra = 8'd0; refl_ra = 8'd0; deck_ra = 8'd0;
    mod_req.start = 1'b0;
    mod_req.seed  = seed_sel;
    div_req.start = 1'b0;
    div_req.num   = mod_rsp.rem[7:0];
    div_req.den   = {1'b0, k} + 9'd1;
    unique case (state)
      orbc_pkg::ST_CLR: begin
        fwd_we = 1'b1; inv_we = 1'b1; refl_we = 1'b1; deck_we = 1'b1;
      end
      orbc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        fwd_ra  = in_ch.plain_byte + bp;  // counter mode: first offset is the position
        deck_ra = bp;
      end
      orbc_pkg::ST_CB:  deck_ra = deck_rd;
      orbc_pkg::ST_CC:  fwd_ra  = c + o1;
      orbc_pkg::ST_CR:  refl_ra = fwd_rd + so;
      orbc_pkg::ST_CI:  inv_ra  = refl_rd - so;
      orbc_pkg::ST_INIT: begin
        fwd_we = 1'b1; deck_we = 1'b1; refl_we = 1'b1;
        fwd_wd = cnt[7:0]; deck_wd = cnt[7:0];
      end
      orbc_pkg::ST_LMODS: mod_req.start = 1'b1;
      orbc_pkg::ST_LMODW: div_req.start = mod_rsp.done;
      orbc_pkg::ST_SW0: begin
        fwd_ra = k; deck_ra = k;
      end
      orbc_pkg::ST_SW1: begin
        fwd_ra = ic; deck_ra = ic;
      end
      orbc_pkg::ST_SW2: begin
        fwd_we = !deck_mode; deck_we = deck_mode;
        fwd_wa = k; deck_wa = k;
        fwd_wd = m_rd; deck_wd = m_rd;
      end
      orbc_pkg::ST_SW3: begin
        fwd_we = !deck_mode; deck_we = deck_mode;
        fwd_wa = ic; deck_wa = ic;
        fwd_wd = tk; deck_wd = tk;
        refl_ra = k;
      end
      orbc_pkg::ST_RK: begin
        div_req.start = (refl_rd == 8'd0);
        div_req.num   = r_hi;
        div_req.den   = {1'b0, k};
      end
      orbc_pkg::ST_PRD: refl_ra = ic;
      orbc_pkg::ST_PW0: begin
        refl_we = 1'b1; refl_wa = k; refl_wd = ic;
      end
      orbc_pkg::ST_PW1: begin
        refl_we = 1'b1; refl_wa = ic; refl_wd = k;
      end
      orbc_pkg::ST_INV: begin
        fwd_ra = cnt[7:0];
        inv_we = (cnt != 9'd0);
        inv_wa = fwd_rd;
        inv_wd = 8'(cnt - 9'd1);
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_head    <= 64'd0;
      key_tail    <= '0;
      secure_mode <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.idx)
        orbc_pkg::REG_KEY_HEAD:    key_head    <= cfg_ch.data;
        orbc_pkg::REG_KEY_TAIL:    key_tail    <= cfg_ch.data[orbc_pkg::KEY_TAIL_W-1:0];
        orbc_pkg::REG_SECURE_MODE: secure_mode <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= orbc_pkg::ST_CLR;
      cnt        <= 9'd0;
      kmod       <= 4'd0;
      deck_mode  <= 1'b0;
      sched_seed <= 32'd0;
      shuf_seed  <= orbc_pkg::SEED_START;
      bp         <= 8'd0;
      rev        <= 8'd0;
      so         <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // drop the result once taken; the result states reload it themselves
      if (out_ch.valid && out_ch.ready && state != orbc_pkg::ST_CO
          && state != orbc_pkg::ST_CW) out_valid <= 1'b0;
      unique case (state)
        orbc_pkg::ST_CLR: cnt <= (cnt[7:0] == orbc_pkg::IDX_MASK) ? 9'd0 : cnt + 9'd1;
        orbc_pkg::ST_IDLE: begin
          if (in_acc) begin
            c   <= in_ch.plain_byte;
            o1  <= bp;
            cnt <= 9'd0;
            if (in_ch.cmd == orbc_pkg::CMD_REKEY) sched_seed <= orbc_pkg::SEED_START;
          end
        end
        orbc_pkg::ST_CB: o1 <= deck_rd;
        orbc_pkg::ST_CC: so <= deck_rd;
        orbc_pkg::ST_CO, orbc_pkg::ST_CW: begin
          if (state == orbc_pkg::ST_CO) res <= ciph;
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= (state == orbc_pkg::ST_CO) ? ciph : res;
            bp        <= bp + 8'd1;
            if (bp == orbc_pkg::IDX_MASK) begin
              rev <= rev + 8'd1;
              if (secure_mode) begin
                cnt       <= 9'd0;
                kmod      <= 4'd0;
                deck_mode <= 1'b1;
              end else begin
                so <= rev + 8'd1;
              end
            end
          end
        end
        orbc_pkg::ST_KS: begin
          sched_seed <= sched_seed * key_word(key_head, key_tail, cnt[3:0])
                        + {28'd0, cnt[3:0]};
          cnt <= (cnt[3:0] == 4'(orbc_pkg::KEY_LENGTH - 1)) ? 9'd0 : cnt + 9'd1;
        end
        orbc_pkg::ST_INIT: begin
          cnt <= (cnt[7:0] == orbc_pkg::IDX_MASK) ? 9'd0 : cnt + 9'd1;
          kmod      <= 4'd0;
          deck_mode <= 1'b0;
        end
        orbc_pkg::ST_LSEED: begin
          if (deck_mode) shuf_seed <= (shuf_seed << 2) + shuf_seed + kw;
          else sched_seed <= (sched_seed << 2) + sched_seed + kw;
        end
        orbc_pkg::ST_LMODW: if (mod_rsp.done) r_hi <= mod_rsp.rem[15:8];
        orbc_pkg::ST_LDIVW: if (div_rsp.done) ic <= div_rsp.rem;
        orbc_pkg::ST_SW1:   tk <= m_rd;
        orbc_pkg::ST_DIV2W: begin
          if (div_rsp.done) begin
            ic    <= div_rsp.rem;
            tries <= 8'd0;
          end
        end
        orbc_pkg::ST_PCK: begin
          // advance the probe, wrapping below k
          if (refl_rd != 8'd0 && tries < k) begin
            ic    <= (ic_inc == {1'b0, k}) ? 8'd0 : ic_inc[7:0];
            tries <= tries + 8'd1;
          end
        end
        orbc_pkg::ST_LNEXT: begin
          cnt  <= (cnt[7:0] == orbc_pkg::IDX_MASK) ? 9'd0 : cnt + 9'd1;
          kmod <= (kmod == 4'(orbc_pkg::KEY_LENGTH - 1)) ? 4'd0 : kmod + 4'd1;
          if (cnt[7:0] == orbc_pkg::IDX_MASK) deck_mode <= 1'b0;
        end
        orbc_pkg::ST_INV: begin
          cnt <= cnt[8] ? 9'd0 : cnt + 9'd1;
          if (cnt[8]) begin
            bp  <= 8'd0;
            rev <= 8'd0;
            so  <= 8'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- tb/orbc_checker.sv -----
// orbc_checker: watches the input, result and configuration channels of the
// one-rotor byte cipher, predicts each result word and compares it.
// Depends on orbc_pkg and on the interfaces in orbc_if.
module orbc_checker (
  input  logic clk,
  input  logic rst,
  orbc_in_if   in_ch,
  orbc_out_if  out_ch,
  orbc_cfg_if  cfg_ch,
  output int   errors,
  output int   pending
);

  logic [63:0]         key_head;
  logic [orbc_pkg::KEY_TAIL_W-1:0] key_tail;
  logic                secure;

  logic [7:0]  fwd [orbc_pkg::ROTOR_SIZE];
  logic [7:0]  inv [orbc_pkg::ROTOR_SIZE];
  logic [7:0]  refl [orbc_pkg::ROTOR_SIZE];
  logic [7:0]  deck [orbc_pkg::ROTOR_SIZE];
  logic [7:0]  pos, revs, off2;
  logic [31:0] sched_seed, shuf_seed;

  logic [7:0] expected_bytes [$];

  function automatic logic [31:0] key_byte(int j);
    logic [7:0] b;
    if (j < 8) b = key_head[8*j +: 8];
    else       b = key_tail[8*(j-8) +: 8];
    return {{24{b[7]}}, b};
  endfunction

  // signed remainder by 65521, truncating toward zero
  function automatic logic [31:0] fold_mod(logic [31:0] s);
    logic [31:0] m;
    if (s[31]) begin
      m = (32'd0 - s) % 32'd65521;
      return 32'd0 - m;
    end
    return s % 32'd65521;
  endfunction

  function automatic void reshuffle_deck();
    int k, ic;
    logic [31:0] r;
    logic [7:0] t;
    for (int i = 0; i < orbc_pkg::ROTOR_SIZE; i++) begin
      k = orbc_pkg::ROTOR_SIZE - 1 - i;
      shuf_seed = 32'd5 * shuf_seed + key_byte(i % orbc_pkg::KEY_LENGTH);
      r = fold_mod(shuf_seed);
      ic = int'(r[7:0]) % (k + 1);
      t = deck[k]; deck[k] = deck[ic]; deck[ic] = t;
    end
  endfunction

  task automatic rebuild_tables();
    int k, ic, tries;
    logic [31:0] r;
    logic [7:0] t;
    sched_seed = orbc_pkg::SEED_START;
    for (int i = 0; i < orbc_pkg::KEY_LENGTH; i++)
      sched_seed = sched_seed * key_byte(i) + 32'(i);
    for (int i = 0; i < orbc_pkg::ROTOR_SIZE; i++) begin
      fwd[i] = 8'(i); deck[i] = 8'(i); refl[i] = 8'd0;
    end
    for (int i = 0; i < orbc_pkg::ROTOR_SIZE; i++) begin
      k = orbc_pkg::ROTOR_SIZE - 1 - i;
      sched_seed = 32'd5 * sched_seed + key_byte(i % orbc_pkg::KEY_LENGTH);
      r = fold_mod(sched_seed);
      ic = int'(r[7:0]) % (k + 1);
      t = fwd[k]; fwd[k] = fwd[ic]; fwd[ic] = t;
      r = r >> 8;
      // last slot never pairs: it would divide by zero
      if (refl[k] != 0 || k == 0) continue;
      ic = int'(r[7:0]) % k;
      tries = 0;
      while (refl[ic] != 0 && tries < k) begin
        ic = (ic + 1) % k;
        tries++;
      end
      if (refl[ic] != 0) continue;
      refl[k] = 8'(ic);
      refl[ic] = 8'(k);
    end
    for (int i = 0; i < orbc_pkg::ROTOR_SIZE; i++) inv[fwd[i]] = 8'(i);
    pos = 0; revs = 0; off2 = 0;
  endtask

  function automatic logic [7:0] cipher_byte_of(logic [7:0] c);
    int o1, o2, v;
    if (secure) begin
      o1 = deck[pos];
      off2 = deck[o1];
    end else begin
      o1 = pos;
    end
    o2 = off2;
    v = fwd[(c + o1) & 255];
    v = refl[(v + o2) & 255];
    v = inv[(v - o2) & 255];
    pos = pos + 8'd1;
    if (pos == 0) begin
      revs = revs + 8'd1;
      if (secure) reshuffle_deck();
      else off2 = revs;
    end
    return 8'((v - o1) & 255);
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: cipher_byte got %02h expected %02h", what, got, want);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      key_head = 0; key_tail = 0; secure = 0;
      for (int i = 0; i < orbc_pkg::ROTOR_SIZE; i++) begin
        fwd[i] = 0; inv[i] = 0; refl[i] = 0; deck[i] = 0;
      end
      pos = 0; revs = 0; off2 = 0;
      sched_seed = 0; shuf_seed = orbc_pkg::SEED_START;
      expected_bytes.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.idx)
          orbc_pkg::REG_KEY_HEAD:    key_head = cfg_ch.data;
          orbc_pkg::REG_KEY_TAIL:    key_tail = cfg_ch.data[orbc_pkg::KEY_TAIL_W-1:0];
          orbc_pkg::REG_SECURE_MODE: secure = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0)
          report("no word expected", out_ch.cipher_byte, 8'h00);
        else if (out_ch.cipher_byte !== expected_bytes[0])
          report("wrong word", out_ch.cipher_byte, expected_bytes.pop_front());
        else
          void'(expected_bytes.pop_front());
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == orbc_pkg::CMD_REKEY) rebuild_tables();
        else expected_bytes.push_back(cipher_byte_of(in_ch.plain_byte));
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for the one-rotor byte cipher.
// Depends on orbc_pkg, orbc_if, the cipher RTL and tb/orbc_checker.
module tb_top;

  logic clk, rst;
  int   errors, pending;

  orbc_in_if  in_ch();
  orbc_out_if out_ch();
  orbc_cfg_if cfg_ch();

  one_rotor_byte_cipher_top DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  orbc_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Flag each handshake at the edge it happens, so the driving side can
  // read it at the next falling edge without racing the block.
  logic in_fire, cfg_fire;
  always @(posedge clk) begin
    in_fire  <= in_ch.valid && in_ch.ready;
    cfg_fire <= cfg_ch.valid && cfg_ch.ready;
  end

  // Receiver: stall density is redrawn periodically, sometimes none at all.
  // A squeeze request holds ready low for a long stretch, once, so the
  // block fills up and has to push back on its input.
  logic squeeze;
  bit   squeeze_done;
  int   hold_left, stall_pct, rx_cycle;
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0; stall_pct = 0; rx_cycle = 0; squeeze_done = 0;
  end
  always @(negedge clk) begin
    if (squeeze && !squeeze_done) begin
      squeeze_done = 1;
      hold_left = 400;
    end
    if (rx_cycle % 64 == 0) begin
      case ($urandom_range(0, 3))
        0, 1: stall_pct = 0;
        2:    stall_pct = 40;
        default: stall_pct = 85;
      endcase
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Sender state: bursts of random length, random gaps between them.
  int burst_left;

  // Offer one word and hold it until taken; called and returns at a falling edge.
  task automatic push_word(logic cmd, logic [7:0] b);
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.plain_byte = b;
    do @(negedge clk); while (!in_fire);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic cipher_word(logic [7:0] b);
    push_word(orbc_pkg::CMD_CIPHER, b);
  endtask

  task automatic rekey_word();
    push_word(orbc_pkg::CMD_REKEY, 8'($urandom));
  endtask

  // Drop valid, let every result arrive, then hold a quiet spell long enough
  // for a deck reshuffle to finish before any register changes.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6000) @(negedge clk);
  endtask

  task automatic write_reg(logic [orbc_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.idx = idx;
    cfg_ch.data = data;
    do @(negedge clk); while (!cfg_fire);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      2: return 64'h8080_8080_8080_8080;
      3: return 64'h7f7f_7f7f_7f7f_7f7f;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst = 1'b1;
    squeeze = 1'b0;
    in_ch.valid = 1'b0; in_ch.cmd = orbc_pkg::CMD_CIPHER; in_ch.plain_byte = 8'h00;
    cfg_ch.valid = 1'b0; cfg_ch.idx = orbc_pkg::REG_KEY_HEAD; cfg_ch.data = '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // cipher on the all-zero tables before any rekey
    cipher_word(8'h00); cipher_word(8'hff); cipher_word(8'haa);
    // rekey with all-zero key bytes
    rekey_word();
    cipher_word(8'h00); cipher_word(8'hff);
    settle();

    // all-ones key, counter mode; junk above the tail width must be dropped
    write_reg(orbc_pkg::REG_KEY_HEAD, '1);
    write_reg(orbc_pkg::REG_KEY_TAIL, 64'hdead_beff_ffff_ffff);
    write_reg(orbc_pkg::REG_SECURE_MODE, 64'h0);
    rekey_word();
    cipher_word(8'h00); cipher_word(8'hff); cipher_word(8'h80); cipher_word(8'h7f);
    settle();

    // mixed-sign key in secure mode
    write_reg(orbc_pkg::REG_KEY_HEAD, 64'h8001_7f80_ff00_0102);
    write_reg(orbc_pkg::REG_KEY_TAIL, 64'h00_80_7f_ff_01);
    write_reg(orbc_pkg::REG_SECURE_MODE, 64'hffff_ffff_ffff_fffe | 64'h1);
    rekey_word();
    cipher_word(8'h55); cipher_word(8'haa); cipher_word(8'h01); cipher_word(8'hfe);
    settle();

    // Random phases: new keys and mode each time, rekey only sometimes, so
    // keys change under a live stream and the mode toggles mid-stream.
    // The byte counter goes round where phases run on without a rekey.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(orbc_pkg::REG_KEY_HEAD, pick_key());
      write_reg(orbc_pkg::REG_KEY_TAIL, pick_key());
      write_reg(orbc_pkg::REG_SECURE_MODE,
                64'(ph % 2) ^ 64'($urandom_range(0, 3) == 0));
      if (ph == 0 || $urandom_range(0, 1)) rekey_word();
      for (int n = 0; n < 140; n++) begin
        if (ph == 2 && n == 20) squeeze = 1'b1;
        if (n > 0 && n < 139 && $urandom_range(0, 199) == 0) rekey_word();
        else cipher_word(8'($urandom));
      end
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
